>>> src/lmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmq_pkg
// Shared types and fixed-point constants of the Lloyd-Max pixel quantizer.
// ----------------------------------------------------------------------------
package lmq_pkg;

  localparam int unsigned LEVEL_W  = 18;  // unsigned 10.8
  localparam int unsigned DEC_W    = 20;  // unsigned 11.9
  localparam int unsigned BSEL_W   = 12;  // bin bound derived from a decision
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned ITER_W   = 16;
  localparam int unsigned CODE_W   = 8;

  localparam logic [LEVEL_W-1:0]  LEVEL_MAX    = '1;
  localparam logic [SAMPLE_W-1:0] KEY_MAX      = 10'd1023;
  localparam logic [DEC_W-1:0]    TOP_DECISION = 20'h8_0000;
  localparam logic [DEC_W-1:0]    CEIL_ADD     = 20'd511;
  localparam logic [ITER_W-1:0]   ITER_RESET   = 16'd10001;
  localparam logic [LEVEL_W:0]    CODE_HALF    = 19'd512;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_TRAIN = 2'd1,
    FUNC_QUANT = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_e;

  typedef enum logic {
    KIND_CODE  = 1'b0,
    KIND_TRAIN = 1'b1
  } kind_e;

endpackage

>>> src/lmq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmq_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module lmq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/lmq_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmq_div
// Restoring divider, one quotient bit per cycle; quotient must fit QW bits.
// ----------------------------------------------------------------------------
module lmq_div #(
  parameter int unsigned DW = 30,
  parameter int unsigned QW = 18
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DW+QW-1:0]   dividend_i,
  input  logic [DW-1:0]      divisor_i,
  output logic               done_o,
  output logic [QW-1:0]      quotient_o
);

  localparam int unsigned RW = DW + QW;
  localparam int unsigned CNTW = $clog2(QW + 1);

  logic            run_q, run_d;
  logic            done_q, done_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [RW-1:0]   rem_q, rem_d;
  logic [RW-1:0]   ds_q, ds_d;
  logic [QW-1:0]   quo_q, quo_d;
  logic            fit;

  assign fit = rem_q >= ds_q;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    ds_d   = ds_q;
    quo_d  = quo_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CNTW'(QW);
      rem_d = dividend_i;
      ds_d  = RW'(divisor_i) << (QW - 1);
      quo_d = '0;
    end else if (run_q) begin
      if (fit) begin
        rem_d = rem_q - ds_q;
      end
      quo_d = {quo_q[QW-2:0], fit};
      ds_d  = ds_q >> 1;
      cnt_d = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    ds_q  <= ds_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> src/lloyd_max_pixel_quantizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lloyd_max_pixel_quantizer
// Three-channel Lloyd-Max quantizer: histogram, training and lookup over RAMs.
// ----------------------------------------------------------------------------
// Add: histogram read, then write back. Clear: one histogram write per bin of the channel.
// Quantize: one decision RAM read per cycle in the scan.
// Train: an init pass writes levels and decisions, then each round sweeps the
// bins of every interval and divides, the divider skipped for an empty interval.
// Results are one-cycle strobes; the receiver cannot stall.
// Reset clears the histogram RAM of every channel while busy is high.
module lloyd_max_pixel_quantizer
  import lmq_pkg::*;
#(
  parameter int unsigned LEVELS      = 256,
  parameter int unsigned BINS        = 1024,
  parameter int unsigned COUNT_WIDTH = 20,
  parameter int unsigned CHANNELS    = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          func_i,
  input  logic [1:0]          channel_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [ITER_W-1:0]   cfg_data_i,
  output logic                valid_o,
  output logic                kind_o,
  output logic [1:0]          result_channel_o,
  output logic [CODE_W-1:0]   code_o,
  output logic [7:0]          level_index_o
);

  localparam int unsigned BW  = $clog2(BINS);
  localparam int unsigned HAW = $clog2(CHANNELS * BINS);
  localparam int unsigned RAW = $clog2(CHANNELS * LEVELS);
  localparam int unsigned DAW = $clog2(CHANNELS * (LEVELS + 1));
  localparam int unsigned IW  = $clog2(LEVELS + 1);
  localparam int unsigned DW  = COUNT_WIDTH + BW;
  localparam int unsigned NW  = COUNT_WIDTH + 2 * BW;
  localparam int unsigned QW  = BW + 8;
  localparam int unsigned RW  = DW + QW;

  localparam logic [IW-1:0]     I_LAST   = IW'(LEVELS - 1);
  localparam logic [IW-1:0]     I_TOP    = IW'(LEVELS);
  localparam logic [BSEL_W-1:0] BIN_LAST = BSEL_W'(BINS - 1);
  localparam logic [HAW-1:0]    HIST_END = HAW'(CHANNELS * BINS - 1);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_ADD_RD, S_ADD_WR, S_INIT, S_RSTART, S_RWAIT, S_LOAD,
    S_LWAIT, S_HSCAN, S_DIV, S_DWAIT, S_NEXT, S_Q_FIRST, S_Q_SCAN, S_Q_LVL,
    S_Q_OUT
  } state_e;

  state_e              state_q, state_d;
  func_e               func_in;
  logic [1:0]          ch_q, ch_d;
  logic [SAMPLE_W-1:0] s_q, s_d;
  logic [HAW-1:0]      hbase_q, hbase_d;
  logic [RAW-1:0]      rbase_q, rbase_d;
  logic [DAW-1:0]      dbase_q, dbase_d;
  logic [HAW-1:0]      hcnt_q, hcnt_d;
  logic [HAW-1:0]      hend_q, hend_d;
  logic [IW-1:0]       i_q, i_d;
  logic [ITER_W-1:0]   rnd_q, rnd_d;
  logic [ITER_W-1:0]   iters_q, iters_d;
  logic [LEVEL_W-1:0]  prev_q, prev_d, cur_q, cur_d, nxt_q, nxt_d;
  logic [BSEL_W-1:0]   j_q, j_d, hi_q, hi_d;
  logic                iss_q, iss_d, pend_q, pend_d;
  logic [BW-1:0]       pj_q, pj_d;
  logic [DW-1:0]       den_q, den_d;
  logic [NW-1:0]       num_q, num_d;
  logic [DEC_W-1:0]    dprev_q, dprev_d;
  logic                valid_q, valid_d;
  kind_e               kind_q, kind_d;
  logic [CODE_W-1:0]   code_q, code_d;
  logic [7:0]          lidx_q, lidx_d;

  logic               h_we, h_re, r_we, r_re, d_we, d_re;
  logic [HAW-1:0]     h_waddr, h_raddr;
  logic [RAW-1:0]     r_waddr, r_raddr;
  logic [DAW-1:0]     d_waddr, d_raddr;
  logic [COUNT_WIDTH-1:0] h_wdata, h_rdata;
  logic [LEVEL_W-1:0] r_wdata, r_rdata;
  logic [DEC_W-1:0]   d_wdata, d_rdata;

  logic               div_start, div_done;
  logic [QW-1:0]      div_quo;
  logic [RW-1:0]      div_num;

  logic               ch_ok, s_ok, last;
  logic [HAW-1:0]     hb_in, hadd;
  logic [DEC_W-1:0]   dlo, dhi, key;
  logic [DEC_W:0]     lo_sum, hi_sum;
  logic [BSEL_W-1:0]  lo, hi_raw, hi;
  logic [LEVEL_W:0]   code_sum;
  logic [8:0]         code9;
  logic [LEVEL_W-1:0] new_lv;

  assign func_in = func_e'(func_i);
  assign ch_ok   = {1'b0, channel_i} < 3'(CHANNELS);
  assign s_ok    = {3'b0, s_q} < 13'(BINS);
  assign hb_in   = HAW'(channel_i) * HAW'(BINS);
  assign hadd    = hbase_q + HAW'(s_q);
  assign last    = i_q == I_LAST;
  assign key     = DEC_W'({s_q, 9'b0});

  assign dlo    = (i_q == '0) ? '0 : DEC_W'(cur_q) + DEC_W'(prev_q);
  assign dhi    = last ? TOP_DECISION : DEC_W'(r_rdata) + DEC_W'(cur_q);
  assign lo_sum = {1'b0, dlo} + {1'b0, CEIL_ADD};
  assign hi_sum = {1'b0, dhi} + {1'b0, CEIL_ADD};
  assign lo     = lo_sum[DEC_W:9];
  assign hi_raw = last ? hi_sum[DEC_W:9] : {1'b0, dhi[DEC_W-1:9]};
  assign hi     = (hi_raw > BIN_LAST) ? BIN_LAST : hi_raw;

  assign code_sum = {1'b0, r_rdata} + CODE_HALF;
  assign code9    = code_sum[LEVEL_W:10];
  assign new_lv   = (div_quo > QW'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_W'(div_quo);
  assign div_num  = RW'({num_q, 8'b0}) + RW'(den_q >> 1);

  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    s_d     = s_q;
    hbase_d = hbase_q;
    rbase_d = rbase_q;
    dbase_d = dbase_q;
    hcnt_d  = hcnt_q;
    hend_d  = hend_q;
    i_d     = i_q;
    rnd_d   = rnd_q;
    iters_d = iters_q;
    prev_d  = prev_q;
    cur_d   = cur_q;
    nxt_d   = nxt_q;
    j_d     = j_q;
    hi_d    = hi_q;
    iss_d   = iss_q;
    pend_d  = pend_q;
    pj_d    = pj_q;
    den_d   = den_q;
    num_d   = num_q;
    dprev_d = dprev_q;
    valid_d = 1'b0;
    kind_d  = kind_q;
    code_d  = code_q;
    lidx_d  = lidx_q;
    h_we = 1'b0; h_waddr = hcnt_q; h_wdata = '0;
    h_re = 1'b0; h_raddr = hadd;
    r_we = 1'b0; r_waddr = rbase_q + RAW'(i_q); r_wdata = new_lv;
    r_re = 1'b0; r_raddr = rbase_q + RAW'(i_q);
    d_we = 1'b0; d_waddr = dbase_q + DAW'(i_q); d_wdata = dlo;
    d_re = 1'b0; d_raddr = dbase_q;
    div_start = 1'b0;

    if (cfg_valid_i) begin
      iters_d = cfg_data_i;
    end

    case (state_q)
      S_CLR: begin
        h_we = 1'b1;
        hcnt_d = hcnt_q + HAW'(1);
        if (hcnt_q == hend_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i && ch_ok) begin
          ch_d    = channel_i;
          s_d     = sample_i;
          hbase_d = hb_in;
          rbase_d = RAW'(channel_i) * RAW'(LEVELS);
          dbase_d = DAW'(channel_i) * DAW'(LEVELS + 1);
          i_d     = '0;
          case (func_in)
            FUNC_ADD: state_d = S_ADD_RD;
            FUNC_CLEAR: begin
              hcnt_d  = hb_in;
              hend_d  = hb_in + HAW'(BINS - 1);
              state_d = S_CLR;
            end
            FUNC_TRAIN: state_d = S_INIT;
            FUNC_QUANT: begin
              if (sample_i == KEY_MAX) begin
                i_d     = I_LAST;
                state_d = S_Q_LVL;
              end else begin
                state_d = S_Q_FIRST;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_ADD_RD: begin
        h_re = s_ok;
        state_d = s_ok ? S_ADD_WR : S_IDLE;
      end
      S_ADD_WR: begin
        h_we    = 1'b1;
        h_waddr = hadd;
        h_wdata = (h_rdata == {COUNT_WIDTH{1'b1}}) ? h_rdata
                                                   : h_rdata + COUNT_WIDTH'(1);
        state_d = S_IDLE;
      end
      S_INIT: begin
        r_we    = i_q != I_TOP;
        r_wdata = LEVEL_W'({i_q, 10'b10_0000_0000});
        d_we    = 1'b1;
        d_wdata = (i_q == I_TOP) ? TOP_DECISION : DEC_W'({i_q, 11'b0});
        i_d     = i_q + IW'(1);
        if (i_q == I_TOP) begin
          rnd_d = '0;
          if (iters_q == '0) begin
            valid_d = 1'b1;
            kind_d  = KIND_TRAIN;
            code_d  = '0;
            lidx_d  = '0;
            state_d = S_IDLE;
          end else begin
            state_d = S_RSTART;
          end
        end
      end
      S_RSTART: begin
        i_d     = '0;
        r_re    = 1'b1;
        r_raddr = rbase_q;
        state_d = S_RWAIT;
      end
      S_RWAIT: begin
        cur_d   = r_rdata;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        r_re    = !last;
        r_raddr = rbase_q + RAW'(i_q) + RAW'(1);
        state_d = S_LWAIT;
      end
      S_LWAIT: begin
        d_we    = i_q != '0;
        nxt_d   = r_rdata;
        j_d     = lo;
        hi_d    = hi;
        iss_d   = lo <= hi;
        pend_d  = 1'b0;
        den_d   = '0;
        num_d   = '0;
        state_d = S_HSCAN;
      end
      S_HSCAN: begin
        h_raddr = hbase_q + HAW'(j_q[BW-1:0]);
        h_re    = iss_q;
        pend_d  = iss_q;
        pj_d    = j_q[BW-1:0];
        j_d     = j_q + BSEL_W'(1);
        if (iss_q && j_q == hi_q) begin
          iss_d = 1'b0;
        end
        if (pend_q) begin
          den_d = den_q + DW'(h_rdata);
          num_d = num_q + NW'(pj_q) * NW'(h_rdata);
        end
        if (!iss_q && !pend_q) begin
          state_d = (den_q != '0) ? S_DIV : S_NEXT;
        end
      end
      S_DIV: begin
        div_start = 1'b1;
        state_d   = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          r_we    = 1'b1;
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        prev_d = cur_q;
        cur_d  = nxt_q;
        i_d    = i_q + IW'(1);
        if (last) begin
          rnd_d = rnd_q + ITER_W'(1);
          if (ITER_W'(rnd_q + ITER_W'(1)) == iters_q) begin
            valid_d = 1'b1;
            kind_d  = KIND_TRAIN;
            code_d  = '0;
            lidx_d  = '0;
            state_d = S_IDLE;
          end else begin
            state_d = S_RSTART;
          end
        end else begin
          state_d = S_LOAD;
        end
      end
      S_Q_FIRST: begin
        d_re    = 1'b1;
        d_raddr = dbase_q;
        i_d     = '0;
        state_d = S_Q_SCAN;
      end
      S_Q_SCAN: begin
        if (i_q != '0 && key >= dprev_q && key < d_rdata) begin
          i_d     = i_q - IW'(1);
          state_d = S_Q_LVL;
        end else if (i_q == I_TOP) begin
          i_d     = I_LAST;
          state_d = S_Q_LVL;
        end else begin
          d_re    = 1'b1;
          d_raddr = dbase_q + DAW'(i_q) + DAW'(1);
          dprev_d = d_rdata;
          i_d     = i_q + IW'(1);
        end
      end
      S_Q_LVL: begin
        r_re    = 1'b1;
        state_d = S_Q_OUT;
      end
      S_Q_OUT: begin
        valid_d = 1'b1;
        kind_d  = KIND_CODE;
        code_d  = (code9 > 9'd255) ? 8'd255 : code9[7:0];
        lidx_d  = 8'(i_q);
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      hcnt_q  <= '0;
      hend_q  <= HIST_END;
      iters_q <= ITER_RESET;
      valid_q <= 1'b0;
      iss_q   <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      hcnt_q  <= hcnt_d;
      hend_q  <= hend_d;
      iters_q <= iters_d;
      valid_q <= valid_d;
      iss_q   <= iss_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q    <= ch_d;
    s_q     <= s_d;
    hbase_q <= hbase_d;
    rbase_q <= rbase_d;
    dbase_q <= dbase_d;
    i_q     <= i_d;
    rnd_q   <= rnd_d;
    prev_q  <= prev_d;
    cur_q   <= cur_d;
    nxt_q   <= nxt_d;
    j_q     <= j_d;
    hi_q    <= hi_d;
    pj_q    <= pj_d;
    den_q   <= den_d;
    num_q   <= num_d;
    dprev_q <= dprev_d;
    kind_q  <= kind_d;
    code_q  <= code_d;
    lidx_q  <= lidx_d;
  end

  lmq_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(CHANNELS * BINS)) u_hist (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .re_i    (h_re),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  lmq_ram #(.WIDTH(LEVEL_W), .DEPTH(CHANNELS * LEVELS)) u_recon (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .re_i    (r_re),
    .raddr_i (r_raddr),
    .rdata_o (r_rdata)
  );

  lmq_ram #(.WIDTH(DEC_W), .DEPTH(CHANNELS * (LEVELS + 1))) u_dec (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .re_i    (d_re),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  lmq_div #(.DW(DW), .QW(QW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign busy_o           = state_q != S_IDLE;
  assign cfg_ready_o      = 1'b1;
  assign valid_o          = valid_q;
  assign kind_o           = kind_q;
  assign result_channel_o = ch_q;
  assign code_o           = code_q;
  assign level_index_o    = lidx_q;

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o) else $error("result strobe while busy");

  a_strobe_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe longer than one cycle");

  a_accept_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> !valid_o) else $error("result right after request");

  a_train_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && kind_o == KIND_TRAIN) |-> (code_o == '0 && level_index_o == '0))
    else $error("train acknowledge carries payload");

endmodule
